/* rtl/svmr_pkg.sv */
package svmr_pkg;

    localparam int MOD_WIDTH     = 32;
    localparam int VALUE_WIDTH   = 64;
    localparam int RESIDUE_WIDTH = 32;

    localparam logic [MOD_WIDTH-1:0] MODULUS_RESET = MOD_WIDTH'(2);

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // front register, queue, one stage per value bit, sign fix, accumulate
    localparam int LATENCY = VALUE_WIDTH + 4;

    typedef enum logic
    {
        REQ_SET = 1'b0,
        REQ_ACC = 1'b1
    } req_t;

    typedef struct packed
    {
        req_t                   mode;
        logic                   neg;
        logic                   qzero;
        logic [VALUE_WIDTH-1:0] mag;
        logic [MOD_WIDTH-1:0]   prior;
    } item_t;

    typedef struct packed
    {
        item_t                item;
        logic [MOD_WIDTH-1:0] rem;
    } stage_t;

endpackage

/* rtl/svmr_front.sv */
module svmr_front
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic                            req_type,
    input  logic [svmr_pkg::VALUE_WIDTH-1:0] signed_value,
    input  logic [svmr_pkg::MOD_WIDTH-1:0]   prior_residue,
    input  logic [svmr_pkg::MOD_WIDTH-1:0]   q,
    input  logic                            push_ready,
    output logic                            busy,
    output logic                            push_valid,
    output svmr_pkg::item_t                 push_item
);

    import svmr_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    item_t item_next;
    logic  take;

    assign busy       = valid_reg && !push_ready;
    assign take       = start && !busy;
    assign push_valid = valid_reg;
    assign push_item  = item_reg;

    always_comb
    begin
        valid_next = take || (valid_reg && !push_ready);

        item_next.mode  = req_t'(req_type);
        item_next.neg   = signed_value[VALUE_WIDTH-1];
        item_next.qzero = (q == '0);
        item_next.prior = prior_residue;
        // most negative value maps to 2^(W-1), which fits as unsigned
        item_next.mag   = signed_value[VALUE_WIDTH-1] ? (~signed_value + 1'b1) : signed_value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item_next;
        end
    end

endmodule

/* rtl/svmr_queue.sv */
module svmr_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    input  svmr_pkg::item_t push_item,
    output logic            push_ready,
    input  logic            pop,
    output logic            head_valid,
    output svmr_pkg::item_t head_item
);

    import svmr_pkg::*;

    item_t               mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg;
    logic [QUEUE_AW:0]   count_next;
    logic                do_push;
    logic                do_pop;

    assign push_ready = (count_reg != (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* rtl/svmr_back.sv */
module svmr_back
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [svmr_pkg::MOD_WIDTH-1:0]     q,
    input  logic                              head_valid,
    input  svmr_pkg::item_t                   head_item,
    output logic                              pop,
    output logic                              done,
    output logic [svmr_pkg::RESIDUE_WIDTH-1:0] residue
);

    import svmr_pkg::*;

    stage_t stage_reg  [VALUE_WIDTH];
    stage_t stage_next [VALUE_WIDTH];
    logic [VALUE_WIDTH-1:0] valid_reg;
    logic [VALUE_WIDTH-1:0] valid_next;

    logic                   fin_valid_reg;
    logic [MOD_WIDTH-1:0]   fin_rem_reg;
    logic [MOD_WIDTH-1:0]   fin_rem_next;
    req_t                   fin_mode_reg;
    logic                   fin_qzero_reg;
    logic [MOD_WIDTH-1:0]   fin_prior_reg;

    logic                     done_reg;
    logic [RESIDUE_WIDTH-1:0] residue_reg;
    logic [RESIDUE_WIDTH-1:0] residue_next;
    logic [MOD_WIDTH:0]       sum;
    logic [MOD_WIDTH:0]       sum_red;
    logic [MOD_WIDTH-1:0]     res;

    stage_t last;

    assign pop     = head_valid;
    assign done    = done_reg;
    assign residue = residue_reg;
    assign last    = stage_reg[VALUE_WIDTH-1];

    // restoring remainder, one value bit per stage, MSB first
    for (genvar i = 0; i < VALUE_WIDTH; i++)
    begin : g_stage
        localparam int BIT = VALUE_WIDTH - 1 - i;
        item_t                it;
        logic [MOD_WIDTH-1:0] rem_in;
        logic [MOD_WIDTH:0]   trial;

        if (i == 0)
        begin : g_first
            assign it            = head_item;
            assign rem_in        = '0;
            assign valid_next[i] = head_valid;
        end
        else
        begin : g_rest
            assign it            = stage_reg[i-1].item;
            assign rem_in        = stage_reg[i-1].rem;
            assign valid_next[i] = valid_reg[i-1];
        end

        always_comb
        begin
            trial              = {rem_in, it.mag[BIT]};
            stage_next[i].item = it;
            if (trial >= {1'b0, q})
            begin
                stage_next[i].rem = MOD_WIDTH'(trial - {1'b0, q});
            end
            else
            begin
                stage_next[i].rem = trial[MOD_WIDTH-1:0];
            end
        end
    end

    always_comb
    begin
        if (last.item.neg && (last.rem != '0))
        begin
            fin_rem_next = q - last.rem;
        end
        else
        begin
            fin_rem_next = last.rem;
        end
    end

    always_comb
    begin
        sum = {1'b0, fin_prior_reg} + {1'b0, fin_rem_reg};
        if (sum >= {1'b0, q})
        begin
            sum_red = sum - {1'b0, q};
        end
        else
        begin
            sum_red = sum;
        end

        if (fin_qzero_reg)
        begin
            res = '0;
        end
        else if (fin_mode_reg == REQ_ACC)
        begin
            res = sum_red[MOD_WIDTH-1:0];
        end
        else
        begin
            res = fin_rem_reg;
        end
        residue_next = RESIDUE_WIDTH'(res);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            fin_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            fin_valid_reg <= valid_reg[VALUE_WIDTH-1];
            done_reg      <= fin_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < VALUE_WIDTH; k++)
        begin
            stage_reg[k] <= stage_next[k];
        end
        fin_rem_reg   <= fin_rem_next;
        fin_mode_reg  <= last.item.mode;
        fin_qzero_reg <= last.item.qzero;
        fin_prior_reg <= last.item.prior;
        residue_reg   <= residue_next;
    end

endmodule

/* rtl/signed_value_modular_reducer.sv */
// Results strobe on done after front, queue, bit-stage, sign-fix, accumulate registers.
// Throughput: one coefficient per cycle; the remainder is a pipeline of one
// compare/subtract stage per value bit, so busy does not rise while results flow.
// The receiver cannot stall: every result is on residue for exactly one cycle.
// Reset (rst_n low, async): pipeline and queue empty, done low, modulus = 2.
module signed_value_modular_reducer
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              req_type,
    input  logic [svmr_pkg::VALUE_WIDTH-1:0]   signed_value,
    input  logic [svmr_pkg::MOD_WIDTH-1:0]     prior_residue,
    input  logic                              modulus_wr,
    input  logic [svmr_pkg::MOD_WIDTH-1:0]     modulus,
    output logic                              done,
    output logic [svmr_pkg::RESIDUE_WIDTH-1:0] residue
);

    import svmr_pkg::*;

    logic [MOD_WIDTH-1:0] modulus_reg;
    logic                 push_valid;
    logic                 push_ready;
    item_t                push_item;
    logic                 head_valid;
    item_t                head_item;
    logic                 pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= MODULUS_RESET;
        end
        else if (modulus_wr)
        begin
            modulus_reg <= modulus;
        end
    end

    svmr_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .req_type      (req_type),
        .signed_value  (signed_value),
        .prior_residue (prior_residue),
        .q             (modulus_reg),
        .push_ready    (push_ready),
        .busy          (busy),
        .push_valid    (push_valid),
        .push_item     (push_item)
    );

    svmr_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    svmr_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q          (modulus_reg),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .done       (done),
        .residue    (residue)
    );

endmodule

/* rtl/svmr_checker.sv */
module svmr_checker
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);

    import svmr_pkg::*;

    logic xfer;

    assign xfer = start && !busy && rst_n;

    // back end never stalls, so the front never backs up
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised while results drain every cycle");

    a_xfer_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        xfer |-> ##LATENCY done)
        else $error("transfer without result at fixed latency");

    a_done_has_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(xfer, LATENCY))
        else $error("result without matching transfer");

endmodule

bind signed_value_modular_reducer svmr_checker u_svmr_checker (.*);

/* dv/signed_value_modular_reducer_tb.sv */
module signed_value_modular_reducer_tb;

    import svmr_pkg::*;

    localparam int                     CYCLE_LIMIT = 200000;
    localparam logic [VALUE_WIDTH-1:0] VALUE_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [VALUE_WIDTH-1:0] VALUE_MIN   = 64'h8000_0000_0000_0001;
    localparam logic [VALUE_WIDTH-1:0] VALUE_MOSTNEG = 64'h8000_0000_0000_0000;
    localparam logic [MOD_WIDTH-1:0]   PRIOR_MAX   = 32'hFFFF_FFFE;
    localparam logic [MOD_WIDTH-1:0]   Q_MAX       = 32'hFFFF_FFFF;

    class residue_scoreboard;
        logic [MOD_WIDTH-1:0]     modulus_q;
        logic [RESIDUE_WIDTH-1:0] pending_residues[$];
        int                       failures;
        int                       coefficients;
        int                       compared;

        function new();
            modulus_q    = MODULUS_RESET;
            failures     = 0;
            coefficients = 0;
            compared     = 0;
        endfunction

        function void set_modulus(logic [MOD_WIDTH-1:0] q);
            modulus_q = q;
        endfunction

        function logic [RESIDUE_WIDTH-1:0] expected_residue(req_t mode,
                                                            logic [VALUE_WIDTH-1:0] value,
                                                            logic [MOD_WIDTH-1:0] prior);
            logic [63:0] q64;
            logic [63:0] mag;
            logic [63:0] rem;
            logic [63:0] sum;
            q64 = {32'd0, modulus_q};
            if (q64 == 64'd0)
                return '0;
            mag = value[VALUE_WIDTH-1] ? (64'd0 - value) : value;
            rem = mag % q64;
            if (value[VALUE_WIDTH-1] && rem != 64'd0)
                rem = q64 - rem;
            if (mode == REQ_ACC)
            begin
                sum = {32'd0, prior} + rem;
                if (sum >= q64)
                    sum = sum - q64;
                rem = sum;
            end
            return rem[RESIDUE_WIDTH-1:0];
        endfunction

        function void note_coefficient(req_t mode, logic [VALUE_WIDTH-1:0] value,
                                       logic [MOD_WIDTH-1:0] prior);
            pending_residues.push_back(expected_residue(mode, value, prior));
            coefficients++;
        endfunction

        function void check_residue(logic [RESIDUE_WIDTH-1:0] got);
            logic [RESIDUE_WIDTH-1:0] want;
            if (pending_residues.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("ERROR: residue 0x%08h with no transfer outstanding", got);
                return;
            end
            want = pending_residues.pop_front();
            compared++;
            if (got !== want)
            begin
                failures++;
                if (failures <= 10)
                    $display("ERROR: residue mismatch, q=0x%08h exp=0x%08h got=0x%08h",
                             modulus_q, want, got);
            end
        endfunction

        function void flag_leftovers();
            if (pending_residues.size() != 0)
            begin
                failures += pending_residues.size();
                $display("ERROR: %0d residues never arrived", pending_residues.size());
            end
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic                     req_type = 1'b0;
    logic [VALUE_WIDTH-1:0]   signed_value = '0;
    logic [MOD_WIDTH-1:0]     prior_residue = '0;
    logic                     modulus_wr = 1'b0;
    logic [MOD_WIDTH-1:0]     modulus = '0;
    logic                     done;
    logic [RESIDUE_WIDTH-1:0] residue;

    residue_scoreboard sb = new();
    int                cycles = 0;
    int                modulus_settings = 1;

    signed_value_modular_reducer u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .req_type      (req_type),
        .signed_value  (signed_value),
        .prior_residue (prior_residue),
        .modulus_wr    (modulus_wr),
        .modulus       (modulus),
        .done          (done),
        .residue       (residue)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("signed_value_modular_reducer_tb: FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (modulus_wr)
                sb.set_modulus(modulus);
            if (start && !busy)
                sb.note_coefficient(req_t'(req_type), signed_value, prior_residue);
            if (done)
                sb.check_residue(residue);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // one transfer; start stays high into the next call when no gap follows
    task automatic send_coefficient(req_t mode, logic [VALUE_WIDTH-1:0] value,
                                    logic [MOD_WIDTH-1:0] prior, bit use_gaps);
        int gap;
        start         <= 1'b1;
        req_type      <= mode;
        signed_value  <= value;
        prior_residue <= prior;
        do
            @(posedge clk);
        while (busy);
        gap = use_gaps ? pick_gap() : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending_residues.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_modulus(logic [MOD_WIDTH-1:0] q);
        drain();
        modulus_wr <= 1'b1;
        modulus    <= q;
        @(posedge clk);
        modulus_wr <= 1'b0;
        modulus_settings++;
    endtask

    task automatic run_directed(logic [MOD_WIDTH-1:0] q);
        logic [63:0]          qq;
        logic [63:0]          vals[12];
        logic [MOD_WIDTH-1:0] prior;
        qq   = {32'd0, q};
        vals = '{64'd0, 64'd1, 64'hFFFF_FFFF_FFFF_FFFF, VALUE_MAX, VALUE_MIN, VALUE_MOSTNEG,
                 qq, 64'd0 - qq, qq * 3, 64'd0 - qq * 3, qq - 1, 64'd1 - qq};
        for (int i = 0; i < 12; i++)
        begin
            case (i % 3)
                0: prior = '0;
                1: prior = q - 1;
                default: prior = PRIOR_MAX;
            endcase
            send_coefficient((i % 2) ? REQ_ACC : REQ_SET, vals[i], prior, 1'b0);
        end
    endtask

    function automatic logic [VALUE_WIDTH-1:0] pick_value(logic [MOD_WIDTH-1:0] q);
        longint k;
        longint qs;
        qs = longint'({32'd0, q});
        k  = longint'($urandom_range(0, 20)) - 10;
        case ($urandom_range(0, 5))
            0: return {$urandom, $urandom};
            1: return longint'($urandom_range(0, 2000)) - 1000;
            2: return k * qs;
            3: return k * qs + longint'($urandom_range(0, 2)) - 1;
            4: return $urandom_range(0, 1) ? VALUE_MAX - $urandom_range(0, 3)
                                           : VALUE_MIN + $urandom_range(0, 3);
            default: return longint'(int'($urandom));
        endcase
    endfunction

    task automatic run_random(logic [MOD_WIDTH-1:0] q, int count, bit use_gaps);
        logic [MOD_WIDTH-1:0] prior;
        for (int i = 0; i < count; i++)
        begin
            if (q >= 2 && $urandom_range(0, 9) != 0)
                prior = $urandom_range(0, q - 1);
            else
                prior = $urandom_range(0, PRIOR_MAX);
            send_coefficient(req_t'($urandom_range(0, 1)), pick_value(q), prior, use_gaps);
        end
    endtask

    initial
    begin
        logic [MOD_WIDTH-1:0] q;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset modulus of 2, no write yet
        send_coefficient(REQ_SET, 64'hFFFF_FFFF_FFFF_FFFD, '0, 1'b0);
        send_coefficient(REQ_ACC, 64'd5, 32'd1, 1'b0);
        write_modulus(32'd7);
        run_directed(32'd7);
        write_modulus(Q_MAX);
        run_directed(Q_MAX);

        write_modulus(32'd2);
        run_random(32'd2, 80, 1'b1);
        write_modulus(32'd3);
        run_random(32'd3, 80, 1'b1);
        write_modulus(Q_MAX);
        run_random(Q_MAX, 120, 1'b0);
        write_modulus(32'h8000_0000);
        run_random(32'h8000_0000, 80, 1'b1);
        q = $urandom_range(32'h0100_0000, Q_MAX);
        write_modulus(q);
        run_random(q, 120, 1'b1);
        q = $urandom_range(2, 1000);
        write_modulus(q);
        run_random(q, 120, 1'b0);
        write_modulus(32'h0001_0000);
        run_random(32'h0001_0000, 80, 1'b1);
        write_modulus(32'd1);
        run_random(32'd1, 30, 1'b1);
        write_modulus(32'd0);
        run_random(32'd0, 30, 1'b1);
        q = $urandom_range(2, Q_MAX);
        write_modulus(q);
        run_random(q, 80, 1'b1);

        drain();
        repeat (LATENCY + 10) @(posedge clk);
        sb.flag_leftovers();

        $display("Run covered %0d coefficient transfers under %0d modulus settings;",
                 sb.coefficients, modulus_settings);
        $display("%0d residues compared, %0d failures.", sb.compared, sb.failures);
        if (sb.failures == 0)
            $display("signed_value_modular_reducer_tb: PASS");
        else
            $display("signed_value_modular_reducer_tb: FAIL");
        $finish;
    end

endmodule

/* files.f */
rtl/svmr_pkg.sv
rtl/svmr_front.sv
rtl/svmr_queue.sv
rtl/svmr_back.sv
rtl/signed_value_modular_reducer.sv
rtl/svmr_checker.sv
dv/signed_value_modular_reducer_tb.sv
